// ===== rtl/core/onewire_rom_search_core_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the 1-Wire search core
// Define ASSERT_OFF to compile the checks out.
// ---------------------------------------------------------------------------
`ifndef ONEWIRE_ROM_SEARCH_CORE_ASSERT_SVH
`define ONEWIRE_ROM_SEARCH_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication under synchronous reset
`define OWRS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("owrs check failed");

// next-cycle implication under synchronous reset
`define OWRS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("owrs check failed");

`else

`define OWRS_ASSERT_IMP(label, clk, rst, ante, cons)
`define OWRS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/core/owrs_pkg.sv =====
// ---------------------------------------------------------------------------
// owrs_pkg
// Types, codes and the CRC-8 step shared by the 1-Wire search core.
// ---------------------------------------------------------------------------
package owrs_pkg;

   // request modes
   localparam logic [2:0] MODE_FIRST  = 3'd0;
   localparam logic [2:0] MODE_NEXT   = 3'd1;
   localparam logic [2:0] MODE_BIT    = 3'd2;
   localparam logic [2:0] MODE_TARGET = 3'd3;
   localparam logic [2:0] MODE_SKIP   = 3'd4;

   // response status codes
   localparam logic [2:0] ST_NONE     = 3'd0;
   localparam logic [2:0] ST_BEGUN    = 3'd1;
   localparam logic [2:0] ST_BIT      = 3'd2;
   localparam logic [2:0] ST_FOUND    = 3'd3;
   localparam logic [2:0] ST_NOTFOUND = 3'd4;

   localparam logic [6:0] LAST_BIT     = 7'd64;
   localparam logic [6:0] FAMILY_LIMIT = 7'd9;
   localparam logic [7:0] CRC_POLY     = 8'h8C;

   typedef struct packed {
      logic [2:0] mode;
      logic       presence;
      logic       id_bit;
      logic       complement_bit;
      logic [7:0] family_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        write_valid;
      logic        direction;
      logic [6:0]  bit_index;
      logic [63:0] rom_code;
      logic        last_device;
   } rsp_type;

   typedef struct packed {
      logic [63:0] rom_bits;
      logic [6:0]  last_discrepancy;
      logic [3:0]  family_discrepancy;
      logic        last_device_flag;
      logic        searching;
      logic [6:0]  bit_number;
      logic [6:0]  zero_taken_pos;
      logic [7:0]  crc_accumulator;
   } search_state_type;

   // one byte of the reflected Dallas CRC-8, LSB first
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                            input logic [7:0] data_in);
      logic [7:0] crc;
      logic [7:0] data;
      crc  = crc_in;
      data = data_in;
      for (int k = 0; k < 8; k++) begin
         if (crc[0] ^ data[0]) begin
            crc = (crc >> 1) ^ CRC_POLY;
         end else begin
            crc = crc >> 1;
         end
         data = data >> 1;
      end
      return crc;
   endfunction

endpackage

// ===== rtl/core/owrs_step.sv =====
// ---------------------------------------------------------------------------
// owrs_step
// Next search state and response word for one request word.
// ---------------------------------------------------------------------------
module owrs_step (
   input  owrs_pkg::req_type          req,
   input  owrs_pkg::search_state_type cur,
   output owrs_pkg::search_state_type nxt,
   output owrs_pkg::rsp_type          rsp
);
   import owrs_pkg::*;

   logic [6:0]  n;
   logic [6:0]  n_m1;
   logic [5:0]  pos;
   logic        conflict;
   logic        dir;
   logic [63:0] rom_upd;
   logic [6:0]  lz_upd;
   logic [3:0]  fam_upd;
   logic [7:0]  crc_upd;
   logic        crc_ok;
   logic        found_ok;

   // bit position, clamped to the valid range
   assign n    = (cur.bit_number == 7'd0 || cur.bit_number > LAST_BIT) ? 7'd1
                                                                      : cur.bit_number;
   assign n_m1 = n - 7'd1;
   assign pos  = n_m1[5:0];
   assign conflict = (req.id_bit == req.complement_bit);

   // choose direction, record zeros taken at a conflict, update ROM and CRC
   always_comb begin
      lz_upd  = cur.zero_taken_pos;
      fam_upd = cur.family_discrepancy;
      if (!conflict) begin
         dir = req.id_bit;
      end else if (n < cur.last_discrepancy) begin
         dir = cur.rom_bits[pos];
      end else begin
         dir = (n == cur.last_discrepancy);
      end
      if (conflict && !dir) begin
         lz_upd = n;
         if (n < FAMILY_LIMIT) begin
            fam_upd = n[3:0];
         end
      end
      rom_upd      = cur.rom_bits;
      rom_upd[pos] = dir;
      if (n[2:0] == 3'd0) begin
         crc_upd = crc8_byte(cur.crc_accumulator, rom_upd[{pos[5:3], 3'b000} +: 8]);
      end else begin
         crc_upd = cur.crc_accumulator;
      end
   end

   assign crc_ok   = (crc_upd == 8'd0);
   assign found_ok = crc_ok && (rom_upd[7:0] != 8'd0);

   // decode the mode and build the response
   always_comb begin
      nxt = cur;
      rsp = '0;
      unique case (req.mode) inside
         MODE_FIRST, MODE_NEXT: begin
            if (req.mode == MODE_FIRST) begin
               nxt.last_discrepancy   = '0;
               nxt.family_discrepancy = '0;
               nxt.last_device_flag   = 1'b0;
            end
            nxt.bit_number         = 7'd1;
            nxt.zero_taken_pos     = '0;
            nxt.crc_accumulator    = '0;
            if ((cur.last_device_flag && req.mode == MODE_NEXT) || !req.presence) begin
               nxt.searching          = 1'b0;
               nxt.last_discrepancy   = '0;
               nxt.family_discrepancy = '0;
               nxt.last_device_flag   = 1'b0;
               rsp.status             = ST_NOTFOUND;
            end else begin
               nxt.searching = 1'b1;
               rsp.status    = ST_BEGUN;
            end
         end
         MODE_BIT: begin
            if (cur.searching) begin
               if (req.id_bit && req.complement_bit) begin
                  nxt.searching          = 1'b0;
                  nxt.last_discrepancy   = '0;
                  nxt.family_discrepancy = '0;
                  nxt.last_device_flag   = 1'b0;
                  rsp.status             = ST_NOTFOUND;
               end else begin
                  nxt.rom_bits           = rom_upd;
                  nxt.zero_taken_pos     = lz_upd;
                  nxt.family_discrepancy = fam_upd;
                  nxt.crc_accumulator    = crc_upd;
                  nxt.bit_number         = n + 7'd1;
                  rsp.write_valid        = 1'b1;
                  rsp.direction          = dir;
                  rsp.bit_index          = n;
                  rsp.status             = ST_BIT;
                  // close the pass after the last ROM bit
                  if (n == LAST_BIT) begin
                     nxt.searching = 1'b0;
                     if (found_ok) begin
                        nxt.last_discrepancy = lz_upd;
                        if (lz_upd == 7'd0) begin
                           nxt.last_device_flag = 1'b1;
                        end
                        rsp.status = ST_FOUND;
                     end else begin
                        nxt.last_discrepancy   = '0;
                        nxt.family_discrepancy = '0;
                        nxt.last_device_flag   = 1'b0;
                        rsp.status             = ST_NOTFOUND;
                     end
                  end
               end
            end
         end
         MODE_TARGET: begin
            nxt.searching          = 1'b0;
            nxt.rom_bits           = {56'd0, req.family_byte};
            nxt.last_discrepancy   = LAST_BIT;
            nxt.family_discrepancy = '0;
            nxt.last_device_flag   = 1'b0;
         end
         MODE_SKIP: begin
            nxt.searching          = 1'b0;
            nxt.last_discrepancy   = {3'd0, cur.family_discrepancy};
            nxt.family_discrepancy = '0;
            if (cur.family_discrepancy == 4'd0) begin
               nxt.last_device_flag = 1'b1;
            end
         end
         default: begin
            nxt = cur;
         end
      endcase
      rsp.rom_code    = nxt.rom_bits;
      rsp.last_device = nxt.last_device_flag;
   end

endmodule

// ===== rtl/core/onewire_rom_search_core.sv =====
// ---------------------------------------------------------------------------
// onewire_rom_search_core
// Master-side 1-Wire Search ROM sequencing: start, bit decisions, CRC check.
// ---------------------------------------------------------------------------
//  channel | direction | handshake             | word
//  req     | in        | req_valid / req_ready | owrs_pkg::req_type
//  rsp     | out       | rsp_valid / rsp_ready | owrs_pkg::rsp_type
//
//  One request word is taken every cycle unless a stalled response fills
//  both stages. The decision logic sits between the input register and the
//  response register, which is loaded with the response to the input word.
//  The search state updates as the word leaves the input register.
//  Reset clears the search state, bit_number returns to one.
//  A stalled response holds the input register; req_ready drops only when
//  both stages are full and rsp_ready is low.
// ---------------------------------------------------------------------------
`include "onewire_rom_search_core_assert.svh"

module onewire_rom_search_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  owrs_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output owrs_pkg::rsp_type rsp_data
);
   import owrs_pkg::*;

   logic             in_valid_ff;
   logic             in_valid_in;
   req_type          in_data_ff;
   logic             out_valid_ff;
   logic             out_valid_in;
   rsp_type          out_data_ff;
   search_state_type state_ff;
   search_state_type state_in;
   rsp_type          step_rsp;
   logic             out_free;
   logic             in_adv;

   // advance when the response register is empty or being taken
   assign out_free  = !out_valid_ff || rsp_ready;
   assign in_adv    = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;

   assign in_valid_in  = req_ready ? req_valid : in_valid_ff;
   assign out_valid_in = out_free ? in_valid_ff : out_valid_ff;

   owrs_step u_step (
      .req (in_data_ff),
      .cur (state_ff),
      .nxt (state_in),
      .rsp (step_rsp)
   );

   // hold control and search state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '{bit_number: 7'd1, default: '0};
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (in_adv) begin
            state_ff <= state_in;
         end
      end
   end

   // capture payload words
   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_data_ff <= req_data;
      end
      if (in_adv) begin
         out_data_ff <= step_rsp;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // checks
   `OWRS_ASSERT_IMP(a_search_bit_range, clock, reset, state_ff.searching,
      state_ff.bit_number != 7'd0 && state_ff.bit_number <= LAST_BIT)
   `OWRS_ASSERT_IMP(a_family_range, clock, reset, 1'b1,
      state_ff.family_discrepancy < FAMILY_LIMIT[3:0])
   `OWRS_ASSERT_IMP(a_write_has_index, clock, reset, out_valid_ff && out_data_ff.write_valid,
      out_data_ff.bit_index != 7'd0 && (out_data_ff.status == ST_BIT ||
      out_data_ff.status == ST_FOUND || out_data_ff.status == ST_NOTFOUND))
   `OWRS_ASSERT_NEXT(a_stall_holds_input, clock, reset, in_valid_ff && !out_free,
      in_valid_ff && $stable(in_data_ff))

endmodule

// ===== tb/onewire_rom_search_core_tb.sv =====
// ---------------------------------------------------------------------------
// onewire_rom_search_core_tb
// Drives start, bit-pair and set-up words into the search core and checks
// each response word against a predictor of the search state. The random
// part plays out whole enumerations of simulated buses of one to four
// devices, with noise words and broken sequences mixed in.
// ---------------------------------------------------------------------------
module onewire_rom_search_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import owrs_pkg::*;

   // unused request modes, expected to be ignored
   localparam logic [2:0] MODE_SPARE_LO = 3'd5;
   localparam logic [2:0] MODE_SPARE_HI = 3'd7;

   localparam int ITEM_TARGET  = 1350;
   localparam int STALL_LIMIT  = 4000;
   localparam int STEADY_FROM  = 500;
   localparam int STEADY_UPTO  = 700;
   localparam int DRAIN_CYCLES = 8;

   // ------------------------------------------------------------------------
   // scoreboard: search state predictor and queue of expected response words
   // ------------------------------------------------------------------------
   class search_scoreboard;
      logic [63:0] rom_bits;
      logic [6:0]  last_disc;
      logic [3:0]  family_disc;
      logic        last_dev;
      logic        searching;
      logic [6:0]  bit_no;
      logic [6:0]  zero_taken;
      logic [7:0]  crc;
      rsp_type     pending[$];
      int unsigned faults;

      function new();
         rom_bits   = '0;
         forget_path();
         searching  = 1'b0;
         bit_no     = 7'd1;
         zero_taken = '0;
         crc        = '0;
         faults     = 0;
      endfunction

      // one serial step of the reflected Dallas CRC-8
      static function logic [7:0] crc_step(logic [7:0] c, logic b);
         logic fb;
         fb = c[0] ^ b;
         c  = c >> 1;
         if (fb) begin
            c = c ^ CRC_POLY;
         end
         return c;
      endfunction

      function void forget_path();
         last_disc   = '0;
         family_disc = '0;
         last_dev    = 1'b0;
      endfunction

      // advance the predicted state by one accepted word, queue its response
      function void note_request(req_type w);
         rsp_type    r;
         logic [6:0] n;
         logic [5:0] bit_pos;
         logic       dir;
         r = '0;
         case (w.mode) inside
            MODE_FIRST, MODE_NEXT: begin
               if (w.mode == MODE_FIRST) forget_path();
               bit_no     = 7'd1;
               zero_taken = '0;
               crc        = '0;
               searching  = 1'b0;
               if (last_dev || !w.presence) begin
                  forget_path();
                  r.status = ST_NOTFOUND;
               end else begin
                  searching = 1'b1;
                  r.status  = ST_BEGUN;
               end
            end
            MODE_BIT: begin
               if (searching && w.id_bit && w.complement_bit) begin
                  // nobody answered: abandon the search
                  searching = 1'b0;
                  forget_path();
                  r.status = ST_NOTFOUND;
               end else if (searching) begin
                  n       = (bit_no == 0 || bit_no > LAST_BIT) ? 7'd1 : bit_no;
                  bit_pos = 6'(n - 7'd1);
                  if (w.id_bit != w.complement_bit) begin
                     dir = w.id_bit;
                  end else begin
                     // conflict: follow the old path below the last
                     // discrepancy, take one at it and zero above it
                     if (n < last_disc) dir = rom_bits[bit_pos];
                     else dir = (n == last_disc);
                     if (!dir) begin
                        zero_taken = n;
                        if (n < FAMILY_LIMIT) family_disc = n[3:0];
                     end
                  end
                  rom_bits[bit_pos] = dir;
                  // bits arrive in order from bit one, so a serial CRC
                  // matches a byte-wise one at every byte boundary
                  crc           = crc_step(crc, dir);
                  r.write_valid = 1'b1;
                  r.direction   = dir;
                  r.bit_index   = n;
                  r.status      = ST_BIT;
                  bit_no        = n + 7'd1;
                  if (n == LAST_BIT) begin
                     searching = 1'b0;
                     if (crc == 0 && rom_bits[7:0] != 0) begin
                        last_disc = zero_taken;
                        if (zero_taken == 0) last_dev = 1'b1;
                        r.status = ST_FOUND;
                     end else begin
                        forget_path();
                        r.status = ST_NOTFOUND;
                     end
                  end
               end
            end
            MODE_TARGET: begin
               searching   = 1'b0;
               rom_bits    = {56'd0, w.family_byte};
               last_disc   = LAST_BIT;
               family_disc = '0;
               last_dev    = 1'b0;
            end
            MODE_SKIP: begin
               searching   = 1'b0;
               last_disc   = {3'd0, family_disc};
               family_disc = '0;
               if (last_disc == 0) last_dev = 1'b1;
            end
            default: ;
         endcase
         r.rom_code    = rom_bits;
         r.last_device = last_dev;
         pending.push_back(r);
      endfunction

      function void compare_field(string label, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            $display("[%0t] %s mismatch: expected %0h, actual %0h", $time, label, want, got);
            faults++;
         end
      endfunction

      // compare a response word with the oldest expectation
      function void check_response(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            $display("[%0t] response word with nothing pending: expected none, actual %h",
                     $time, got);
            faults++;
            return;
         end
         want = pending.pop_front();
         compare_field("status", want.status, got.status);
         compare_field("write_valid", want.write_valid, got.write_valid);
         compare_field("direction", want.direction, got.direction);
         compare_field("bit_index", want.bit_index, got.bit_index);
         compare_field("rom_code", want.rom_code, got.rom_code);
         compare_field("last_device", want.last_device, got.last_device);
      endfunction
   endclass

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   search_scoreboard sb = new();
   logic [63:0]      bus_rom[$];
   int               sent = 0;
   int               stall_count = 0;
   logic             steady;

   assign steady = (sent >= STEADY_FROM) && (sent < STEADY_UPTO);

   onewire_rom_search_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // check response words, stall the receiver, watch for a hang
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_response(rsp_data);
      rsp_ready <= steady || ($urandom_range(99) >= 37);
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_count <= 0;
      end else if (stall_count >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         stall_count <= stall_count + 1;
      end
   end

   function automatic logic coin();
      return 1'($urandom_range(1));
   endfunction

   function automatic logic [7:0] any_byte();
      return 8'($urandom_range(255));
   endfunction

   function automatic req_type make_word(logic [2:0] mode, logic presence, logic id_b,
                                         logic cmp_b, logic [7:0] fam);
      req_type w;
      w.mode           = mode;
      w.presence       = presence;
      w.id_bit         = id_b;
      w.complement_bit = cmp_b;
      w.family_byte    = fam;
      return w;
   endfunction

   function automatic req_type noise_word();
      return make_word(3'($urandom_range(7)), coin(), coin(), coin(), any_byte());
   endfunction

   // device ROM with a valid CRC byte, or a spoilt one
   function automatic logic [63:0] make_device(logic [7:0] fam, logic spoil);
      logic [63:0] rom;
      logic [7:0]  c;
      rom      = {$urandom, $urandom};
      rom[7:0] = fam;
      c        = '0;
      for (int i = 0; i < 56; i++) c = search_scoreboard::crc_step(c, rom[6'(i)]);
      rom[63:56] = c ^ {7'd0, spoil};
      return rom;
   endfunction

   // wired-AND read slots of every device still on the predicted path
   function automatic void sample_slots(output logic id_b, output logic cmp_b);
      logic [5:0]  pos;
      logic [63:0] mask;
      pos   = 6'(sb.bit_no - 7'd1);
      mask  = (64'd1 << pos) - 64'd1;
      id_b  = 1'b1;
      cmp_b = 1'b1;
      foreach (bus_rom[i]) begin
         if (((bus_rom[i] ^ sb.rom_bits) & mask) == 0) begin
            id_b  = id_b & bus_rom[i][pos];
            cmp_b = cmp_b & ~bus_rom[i][pos];
         end
      end
   endfunction

   // offer one word, hold it until taken, then predict its response
   task automatic send_word(input req_type w);
      while (!steady && $urandom_range(99) < 37) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
      sb.note_request(w);
      sent++;
   endtask

   // feed bit pairs until the search ends, with the odd stray word
   task automatic run_search();
      logic id_b;
      logic cmp_b;
      while (sb.searching) begin
         if ($urandom_range(24) == 0) send_word(noise_word());
         if (!sb.searching) break;
         sample_slots(id_b, cmp_b);
         send_word(make_word(MODE_BIT, coin(), id_b, cmp_b, any_byte()));
      end
   endtask

   // enumerate one freshly built bus
   task automatic run_bus();
      int         count;
      int         searches;
      logic [7:0] fam_pool[2];
      logic [2:0] start_mode;
      bus_rom.delete();
      foreach (fam_pool[i]) begin
         fam_pool[i] = ($urandom_range(11) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
      end
      count = $urandom_range(1, 4);
      repeat (count) begin
         bus_rom.push_back(make_device(fam_pool[coin()], $urandom_range(9) == 0));
      end
      start_mode = MODE_FIRST;
      if ($urandom_range(3) == 0) begin
         // aim at one family first, sometimes one that is not on the bus
         send_word(make_word(MODE_TARGET, coin(), coin(), coin(),
                             ($urandom_range(2) == 0) ? any_byte() : bus_rom[0][7:0]));
         start_mode = MODE_NEXT;
      end
      searches = 0;
      do begin
         send_word(make_word(start_mode, $urandom_range(19) != 0, coin(), coin(),
                             any_byte()));
         run_search();
         searches++;
         if (!sb.last_dev && $urandom_range(7) == 0) begin
            send_word(make_word(MODE_SKIP, coin(), coin(), coin(), any_byte()));
         end
         start_mode = MODE_NEXT;
      end while (!sb.last_dev && searches < 6 && sent < ITEM_TARGET);
      // sometimes one more search after the enumeration loop ends
      if ($urandom_range(1) == 0) send_word(make_word(MODE_NEXT, 1'b1, 1'b0, 1'b0, 8'h00));
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: idle bit pair, spare modes, each start outcome,
      // every bit-pair pattern, restart and set-up during a search,
      // family skip and a start after the last device
      send_word(make_word(MODE_BIT, 1'b0, 1'b1, 1'b0, 8'h00));
      for (int m = MODE_SPARE_LO; m <= MODE_SPARE_HI; m++) begin
         send_word(make_word(3'(m), 1'b1, 1'b1, 1'b1, 8'hFF));
      end
      send_word(make_word(MODE_FIRST, 1'b0, 1'b0, 1'b0, 8'h00));
      send_word(make_word(MODE_NEXT, 1'b1, 1'b0, 1'b0, 8'h00));
      send_word(make_word(MODE_BIT, 1'b0, 1'b0, 1'b1, 8'h00));
      send_word(make_word(MODE_BIT, 1'b0, 1'b1, 1'b0, 8'h00));
      send_word(make_word(MODE_BIT, 1'b0, 1'b0, 1'b0, 8'h00));
      send_word(make_word(MODE_BIT, 1'b0, 1'b1, 1'b1, 8'h00));
      send_word(make_word(MODE_FIRST, 1'b1, 1'b0, 1'b0, 8'h00));
      send_word(make_word(MODE_BIT, 1'b1, 1'b0, 1'b0, 8'hFF));
      send_word(make_word(MODE_FIRST, 1'b1, 1'b0, 1'b0, 8'h00));
      send_word(make_word(MODE_BIT, 1'b1, 1'b1, 1'b0, 8'hFF));
      send_word(make_word(MODE_TARGET, 1'b0, 1'b0, 1'b0, 8'hFF));
      send_word(make_word(MODE_BIT, 1'b0, 1'b0, 1'b0, 8'h00));
      send_word(make_word(MODE_SKIP, 1'b0, 1'b0, 1'b0, 8'h00));
      send_word(make_word(MODE_NEXT, 1'b1, 1'b0, 1'b0, 8'h00));
      send_word(make_word(MODE_TARGET, 1'b1, 1'b1, 1'b1, 8'h00));
      send_word(make_word(MODE_SKIP, 1'b1, 1'b1, 1'b1, 8'hFF));
      send_word(make_word(MODE_FIRST, 1'b1, 1'b0, 1'b0, 8'h00));
      send_word(make_word(MODE_BIT, 1'b0, 1'b0, 1'b0, 8'h00));
      send_word(make_word(MODE_NEXT, 1'b0, 1'b0, 1'b0, 8'h00));

      // random: whole enumerations of simulated buses
      while (sent < ITEM_TARGET) run_bus();

      // drop valid, drain, then allow for anything stray
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.faults == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/owrs_pkg.sv
rtl/core/owrs_step.sv
rtl/core/onewire_rom_search_core.sv
tb/onewire_rom_search_core_tb.sv
